@@ rtl/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants of the bounded composition enumerator.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int DEF_MAX_PARTS = 8;
  localparam int DEF_PART_BITS = 8;

  // sums of up to eight parts of up to 255 each
  localparam int SUM_W     = 11;
  localparam int CNT_W     = 4;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_LIMITS = 1'b1;

  localparam logic [CNT_W-1:0] PART_COUNT_RST = 4'd8;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [SUM_W-1:0] target;
  } bce_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ok;
  } bce_stat_t;

endpackage

@@ rtl/bce_core.sv @@
// ----------------------------------------------------------------------------
// bce_core
// Sequencer with one shared add/compare datapath that walks the parts one
// per cycle: greedy fill for start, carry scan then refill for next.
// ----------------------------------------------------------------------------
module bce_core #(
  parameter int MAX_PARTS = bce_pkg::DEF_MAX_PARTS,
  parameter int PART_BITS = bce_pkg::DEF_PART_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  bce_pkg::bce_cmd_t              cmd_i,
  input  logic [bce_pkg::CNT_W-1:0]      count_i,
  input  logic [MAX_PARTS*PART_BITS-1:0] limits_i,
  input  logic                           ack_i,
  output bce_pkg::bce_stat_t             stat_o,
  output logic [MAX_PARTS*PART_BITS-1:0] parts_o
);
  import bce_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTS + 1);
  localparam int AW    = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     end_q, end_d;
  logic [SUM_W-1:0]     amt_q, amt_d;
  logic [SUM_W-1:0]     prefix_q, prefix_d;
  logic [SUM_W-1:0]     lowcap_q, lowcap_d;
  logic                 op_q, op_d;
  logic                 ok_q, ok_d;
  logic [PART_BITS-1:0] parts_q [MAX_PARTS];

  logic [PART_BITS-1:0] lim_arr [MAX_PARTS];
  logic [IDX_W-1:0]     n_use;
  logic [PART_BITS-1:0] cur, lim;
  logic [SUM_W-1:0]     cur_w, lim_w, avail, inc, need, v, fill_v;
  logic                 need_pos, hit;
  logic                 wr_en, clr_hi, clr_all;
  logic [IDX_W-1:0]     wr_idx;
  logic [PART_BITS-1:0] wr_data;

  always_comb begin
    for (int i = 0; i < MAX_PARTS; i++) begin
      lim_arr[i] = limits_i[i*PART_BITS +: PART_BITS];
      parts_o[i*PART_BITS +: PART_BITS] = parts_q[i];
    end
  end

  assign n_use = (count_i > CNT_W'(MAX_PARTS)) ? IDX_W'(MAX_PARTS) : IDX_W'(count_i);

  // shared datapath
  assign cur      = parts_q[idx_q[AW-1:0]];
  assign lim      = lim_arr[idx_q[AW-1:0]];
  assign cur_w    = SUM_W'(cur);
  assign lim_w    = SUM_W'(lim);
  assign avail    = prefix_q + cur_w;
  assign inc      = cur_w + SUM_W'(1);
  assign need_pos = avail > lowcap_q;
  assign need     = avail - lowcap_q;
  assign v        = (need_pos && (need > inc)) ? need : inc;
  assign hit      = (cur_w < lim_w) && (v <= lim_w) && (v <= avail);
  assign fill_v   = (lim_w < amt_q) ? lim_w : amt_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    end_d    = end_q;
    amt_d    = amt_q;
    prefix_d = prefix_q;
    lowcap_d = lowcap_q;
    op_d     = op_q;
    ok_d     = ok_q;
    wr_en    = 1'b0;
    wr_idx   = idx_q;
    wr_data  = fill_v[PART_BITS-1:0];
    clr_hi   = 1'b0;
    clr_all  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          clr_hi   = 1'b1;
          op_d     = cmd_i.op;
          idx_d    = '0;
          end_d    = n_use;
          amt_d    = cmd_i.target;
          prefix_d = '0;
          lowcap_d = '0;
          state_d  = (cmd_i.op == OP_START) ? ST_FILL : ST_SCAN;
        end
      end
      ST_FILL: begin
        if (idx_q == end_q) begin
          ok_d    = (op_q == OP_NEXT) || (amt_q == '0);
          state_d = ST_DONE;
        end else begin
          wr_en   = 1'b1;
          wr_data = fill_v[PART_BITS-1:0];
          amt_d   = amt_q - fill_v;
          idx_d   = idx_q + IDX_W'(1);
        end
      end
      ST_SCAN: begin
        if (idx_q == end_q) begin
          clr_all = 1'b1;
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else if (hit) begin
          wr_en   = 1'b1;
          wr_data = v[PART_BITS-1:0];
          amt_d   = avail - v;
          end_d   = idx_q;
          idx_d   = '0;
          state_d = ST_FILL;
        end else begin
          prefix_d = avail;
          lowcap_d = lowcap_q + lim_w;
          idx_d    = idx_q + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      end_q   <= '0;
      op_q    <= OP_START;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
      op_q    <= op_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q    <= amt_d;
    prefix_q <= prefix_d;
    lowcap_q <= lowcap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PARTS; i++) begin
        parts_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_PARTS; i++) begin
        if (clr_all || (clr_hi && (IDX_W'(i) >= n_use))) begin
          parts_q[i] <= '0;
        end else if (wr_en && (wr_idx == IDX_W'(i))) begin
          parts_q[i] <= wr_data;
        end
      end
    end
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign stat_o.ok   = ok_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == ST_IDLE))
    else $error("start while core busy");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FILL) || (state_q == ST_SCAN)) |-> (idx_q <= IDX_W'(MAX_PARTS)))
    else $error("part index out of range");

  a_exhaust_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (op_q == OP_NEXT) && !ok_q) |-> (parts_o == '0))
    else $error("exhausted sequence left nonzero parts");

endmodule

@@ rtl/bounded_composition_enumerator.sv @@
// ----------------------------------------------------------------------------
// bounded_composition_enumerator
// Enumerates compositions of a total into parts with per-part limits.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries operation_i and
// target_sum_i; an item is taken when valid is high and stall is low.
// Operation start greedily fills the parts; next steps them as a
// mixed-radix odometer to the next sequence with the same sum.
// Output channel (out_valid_o / out_stall_i) carries parts_o and ok_o,
// one result per item, held in an output register.
// One item at a time: one add/compare unit visits one part per cycle.
// Start visits each part in use (at most MAX_PARTS) once; next scans the
// parts upward for one it can step, then refills the parts below it; a new
// item is taken only once the core is idle again.
// A finished result waits in the output register while the next item is
// worked on; the core holds its result only if that register is still full.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes part_count
// and part_limits; write only while no item is in flight.
// Reset zeroes the core's parts and all limits and sets part_count to 8.
// ----------------------------------------------------------------------------
module bounded_composition_enumerator #(
  parameter int MAX_PARTS = bce_pkg::DEF_MAX_PARTS,
  parameter int PART_BITS = bce_pkg::DEF_PART_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [bce_pkg::SUM_W-1:0]         target_sum_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [MAX_PARTS*PART_BITS-1:0]    parts_o,
  output logic                              ok_o,
  input  logic                              cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bce_pkg::CFG_W-1:0]         cfg_data_i
);
  import bce_pkg::*;

  logic [CNT_W-1:0]               count_q;
  logic [CFG_W-1:0]               limits_q;
  logic                           out_valid_q;
  logic [MAX_PARTS*PART_BITS-1:0] out_parts_q;
  logic                           out_ok_q;
  logic                           in_acc, ack;
  bce_cmd_t                       cmd;
  bce_stat_t                      stat;
  logic [MAX_PARTS*PART_BITS-1:0] core_parts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= PART_COUNT_RST;
      limits_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PART_COUNT:  count_q  <= cfg_data_i[CNT_W-1:0];
        CFG_PART_LIMITS: limits_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = stat.busy;
  assign in_acc     = in_valid_i && !stat.busy;
  assign ack        = !out_valid_q || !out_stall_i;
  assign cmd.op     = operation_i;
  assign cmd.target = target_sum_i;

  bce_core #(
    .MAX_PARTS (MAX_PARTS),
    .PART_BITS (PART_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .cmd_i    (cmd),
    .count_i  (count_q),
    .limits_i (limits_q[MAX_PARTS*PART_BITS-1:0]),
    .ack_i    (ack),
    .stat_o   (stat),
    .parts_o  (core_parts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done && ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done && ack) begin
      out_parts_q <= core_parts;
      out_ok_q    <= stat.ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign parts_o     = out_parts_q;
  assign ok_o        = out_ok_q;

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.done && ack) |=> (out_valid_q && (out_ok_q == $past(stat.ok))))
    else $error("finished result not loaded into output register");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> stat.busy)
    else $error("core idle after item accepted");

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !stat.done)
    else $error("item accepted while a result is pending");

endmodule
